>>> rtl/ipdv_pkg.sv
// Package for the incremental PD velocity controller: widths, fixed-point
// constants, register indexes, controller states and the command/status structs.
// No dependencies; every other file of the block imports it.
package ipdv_pkg;

  // Fraction bits of the drive accumulator and of the Q8.8 gains.
  localparam int FRAC_BITS = 8;
  localparam int GAIN_FRAC = 8;

  localparam int TIME_W  = 32;
  localparam int VEL_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int DRIVE_W = 32;
  localparam int ACC_W   = 40;

  // Error is target minus measurement, so one bit wider than a velocity.
  localparam int ERR_W  = VEL_W + 1;
  localparam int LERR_W = 18;
  localparam int DIFF_W = LERR_W;
  localparam int MAG_W  = DIFF_W - 1;
  // The magnitude times 1000 fits in ten more bits, since 1000 < 1024.
  localparam int NUM_W  = MAG_W + 10;
  localparam int MULA_W = NUM_W + 1;
  localparam int PROD_W = MULA_W + GAIN_W;
  localparam int SUM_W  = PROD_W + 1;

  localparam int SHL   = (FRAC_BITS >= GAIN_FRAC) ? FRAC_BITS - GAIN_FRAC : 0;
  localparam int SHR   = (FRAC_BITS < GAIN_FRAC) ? GAIN_FRAC - FRAC_BITS : 0;
  localparam int SCL_W = SUM_W + SHL;
  localparam int ADD_W = SCL_W + 1;

  localparam int CNT_W = $clog2(NUM_W);

  localparam int NUM_REGS = 3;
  localparam int CFG_DW   = 32;
  localparam int PADDR_W  = $clog2(4 * NUM_REGS);
  localparam int RIDX_W   = PADDR_W - 2;

  typedef enum logic [RIDX_W-1:0] {
    REG_PROP,
    REG_DERIV,
    REG_TARGET
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_MULP,
    S_MULD,
    S_SUM,
    S_SCALE,
    S_ACC,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic mul_p;
    logic mul_d;
    logic sum;
    logic scale;
    logic acc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] kd;
    logic signed [VEL_W-1:0]  tgt;
  } cfg_t;

endpackage

>>> rtl/ipdv_ifs.sv
// Valid/ready channel interfaces for the sample words and the drive result words.
// Depends on ipdv_pkg for the field widths.
interface ipdv_in_if import ipdv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [TIME_W-1:0]       time_ms;
  logic signed [VEL_W-1:0] measured_velocity;

  modport source(output valid, output time_ms, output measured_velocity, input ready);
  modport sink(input valid, input time_ms, input measured_velocity, output ready);
endinterface

interface ipdv_out_if import ipdv_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive_out;
  logic                      skipped;

  modport source(output valid, output drive_out, output skipped, input ready);
  modport sink(input valid, input drive_out, input skipped, output ready);
endinterface

>>> rtl/ipdv_regs.sv
// APB-style register file holding the gains and the target velocity.
// Depends on ipdv_pkg.
module ipdv_regs import ipdv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic signed [GAIN_W-1:0] kp_r;
  logic signed [GAIN_W-1:0] kd_r;
  logic signed [VEL_W-1:0]  tgt_r;
  reg_idx_t                 idx;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r  <= '0;
      kd_r  <= '0;
      tgt_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_PROP:   kp_r  <= pwdata[GAIN_W-1:0];
        REG_DERIV:  kd_r  <= pwdata[GAIN_W-1:0];
        REG_TARGET: tgt_r <= pwdata[VEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PROP:   prdata = CFG_DW'(kp_r);
      REG_DERIV:  prdata = CFG_DW'(kd_r);
      REG_TARGET: prdata = CFG_DW'(tgt_r);
      default:    prdata = '0;
    endcase
  end

  assign cfg.kp  = kp_r;
  assign cfg.kd  = kd_r;
  assign cfg.tgt = tgt_r;

endmodule

>>> rtl/ipdv_ctrl.sv
// Controller state machine: sequences load, divide, multiply, accumulate and emit; a skip goes from prep to emit.
// Depends on ipdv_pkg for the state type and the command/status structs.
module ipdv_ctrl import ipdv_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        if (sts.skip) begin
          state_nxt = S_EMIT;
        end else begin
          cnt_nxt   = CNT_W'(NUM_W - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_MULP;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_MULP: begin
        cmd.mul_p = 1'b1;
        state_nxt = S_MULD;
      end
      S_MULD: begin
        cmd.mul_d = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // Wait here only while the previous result word is still unread.
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> rtl/ipdv_dp.sv
// Datapath: error and difference, radix-2 divider, shared multiplier,
// saturating accumulator and the output register. Depends on ipdv_pkg.
module ipdv_dp import ipdv_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmd_t                      cmd,
  output sts_t                      sts,
  input  cfg_t                      cfg,
  input  logic [TIME_W-1:0]         in_time,
  input  logic signed [VEL_W-1:0]   in_vel,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [DRIVE_W-1:0] out_drive,
  output logic                      out_skipped
);

  localparam logic signed [SUM_W-1:0] SCL_BIAS = SUM_W'((1 << SHR) - 1);
  localparam logic signed [ACC_W:0]   DRV_BIAS = (ACC_W + 1)'((1 << FRAC_BITS) - 1);
  localparam logic signed [ADD_W-1:0] ACC_MAX =
    {{(ADD_W - ACC_W + 1){1'b0}}, {(ACC_W - 1){1'b1}}};
  localparam logic signed [ADD_W-1:0] ACC_MIN =
    {{(ADD_W - ACC_W + 1){1'b1}}, {(ACC_W - 1){1'b0}}};
  localparam logic signed [ACC_W:0] DRV_MAX =
    {{(ACC_W + 2 - DRIVE_W){1'b0}}, {(DRIVE_W - 1){1'b1}}};
  localparam logic signed [ACC_W:0] DRV_MIN =
    {{(ACC_W + 2 - DRIVE_W){1'b1}}, {(DRIVE_W - 1){1'b0}}};

  // State kept across samples.
  logic [TIME_W-1:0]        last_time_r;
  logic signed [LERR_W-1:0] last_err_r;
  logic signed [ACC_W-1:0]  accum_r;

  // Per-sample working registers.
  logic [TIME_W-1:0]        time_r;
  logic [TIME_W-1:0]        delta_r;
  logic                     skip_r;
  logic signed [ERR_W-1:0]  err_r;
  logic                     neg_r;
  logic [NUM_W-1:0]         num_r;
  logic [NUM_W-1:0]         rem_r;
  logic signed [PROD_W-1:0] prod_p_r;
  logic signed [PROD_W-1:0] prod_d_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SCL_W-1:0]  scl_r;

  logic                      out_valid_r;
  logic signed [DRIVE_W-1:0] out_drive_r;
  logic                      out_skipped_r;

  logic signed [ERR_W-1:0]  err_new;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        diff_abs;
  logic [MAG_W-1:0]         mag;
  logic [NUM_W-1:0]         num_new;
  logic [NUM_W:0]           rem_sh;
  logic                     ge;
  logic [NUM_W-1:0]         rem_new;
  logic signed [MULA_W-1:0] mul_a;
  logic signed [GAIN_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  scl_bias;
  logic signed [ADD_W-1:0]  acc_sum;
  logic signed [ACC_W-1:0]  acc_sat;
  logic signed [ACC_W:0]    drv_bias;
  logic signed [ACC_W:0]    drv_sum;
  logic signed [ACC_W:0]    drv_sh;
  logic signed [DRIVE_W-1:0] drv_sat;

  assign err_new = ERR_W'(cfg.tgt) - ERR_W'(in_vel);

  // Magnitude of the error difference times 1000 as 1024 - 16 - 8.
  always_comb begin
    diff     = DIFF_W'(err_r) - last_err_r;
    diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : diff;
    mag      = diff_abs[MAG_W-1:0];
    num_new  = {mag, 10'b0} - NUM_W'({mag, 4'b0}) - NUM_W'({mag, 3'b0});
  end

  // One restoring division step; quotient bits shift into num_r.
  always_comb begin
    rem_sh  = {rem_r, num_r[NUM_W-1]};
    ge      = (TIME_W + 1)'(rem_sh) >= (TIME_W + 1)'(delta_r);
    rem_new = ge ? NUM_W'(rem_sh - delta_r[NUM_W:0]) : rem_sh[NUM_W-1:0];
  end

  // Shared multiplier: error times kp, then quotient magnitude times kd.
  always_comb begin
    if (cmd.mul_d) begin
      mul_a = $signed({1'b0, num_r});
      mul_b = cfg.kd;
    end else begin
      mul_a = MULA_W'(err_r);
      mul_b = cfg.kp;
    end
    prod = mul_a * mul_b;
  end

  // Rescaling truncates toward zero: the arithmetic shift rounds down, hence the bias on negative sums.
  always_comb begin
    if (sum_r[SUM_W-1]) begin
      scl_bias = SCL_BIAS;
    end else begin
      scl_bias = '0;
    end
  end

  always_comb begin
    acc_sum = ADD_W'(accum_r) + ADD_W'(scl_r);
    if (acc_sum > ACC_MAX) begin
      acc_sat = ACC_MAX[ACC_W-1:0];
    end else if (acc_sum < ACC_MIN) begin
      acc_sat = ACC_MIN[ACC_W-1:0];
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
  end

  always_comb begin
    if (accum_r[ACC_W-1]) begin
      drv_bias = DRV_BIAS;
    end else begin
      drv_bias = '0;
    end
    drv_sum = (ACC_W + 1)'(accum_r) + drv_bias;
    drv_sh  = drv_sum >>> FRAC_BITS;
    if (drv_sh > DRV_MAX) begin
      drv_sat = DRV_MAX[DRIVE_W-1:0];
    end else if (drv_sh < DRV_MIN) begin
      drv_sat = DRV_MIN[DRIVE_W-1:0];
    end else begin
      drv_sat = drv_sh[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      last_err_r  <= '0;
      accum_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.acc) begin
        last_time_r <= time_r;
        last_err_r  <= LERR_W'(err_r);
        accum_r     <= acc_sat;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      time_r  <= in_time;
      delta_r <= in_time - last_time_r;
      skip_r  <= (in_time == last_time_r);
      err_r   <= err_new;
    end
    if (cmd.prep) begin
      neg_r <= diff[DIFF_W-1];
      num_r <= num_new;
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_new;
      num_r <= {num_r[NUM_W-2:0], ge};
    end
    if (cmd.mul_p) begin
      prod_p_r <= prod;
    end
    if (cmd.mul_d) begin
      prod_d_r <= prod;
    end
    if (cmd.sum) begin
      sum_r <= neg_r ? SUM_W'(prod_p_r) - SUM_W'(prod_d_r)
                     : SUM_W'(prod_p_r) + SUM_W'(prod_d_r);
    end
    if (cmd.scale) begin
      scl_r <= SCL_W'((sum_r + scl_bias) >>> SHR) <<< SHL;
    end
    if (cmd.emit) begin
      out_drive_r   <= skip_r ? '0 : drv_sat;
      out_skipped_r <= skip_r;
    end
  end

  assign sts.skip     = skip_r;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign out_drive   = out_drive_r;
  assign out_skipped = out_skipped_r;

endmodule

>>> rtl/incremental_pd_velocity_controller_core.sv
// Top level of the incremental PD velocity controller.
// Depends on ipdv_pkg, ipdv_ifs, ipdv_regs, ipdv_ctrl and ipdv_dp.
//
// Each sample word (time in ms, measured rpm) yields one result word. When
// time has advanced, the block adds error*kp + d(error)/dt*kd to a saturating
// 40-bit accumulator and returns its integer part; a repeated timestamp gives
// drive_out = 0 with skipped set and leaves all state unchanged. Samples are
// processed one at a time: an updating sample passes through prep, the
// one-bit-per-cycle divider that forms the derivative, both multiplies,
// sum, scale, accumulate and emit before the next sample can be taken; a
// skipped sample goes from prep straight to emit. A finished result sits in
// an output register, so the next sample is accepted while it waits to be
// read. Write gains and target only while the block is idle.
module incremental_pd_velocity_controller_core import ipdv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  ipdv_in_if.sink            in_ch,
  ipdv_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  ipdv_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ipdv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  ipdv_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg         (cfg),
    .in_time     (in_ch.time_ms),
    .in_vel      (in_ch.measured_velocity),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_drive   (out_ch.drive_out),
    .out_skipped (out_ch.skipped)
  );

endmodule
